>>> rtl/mexp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// modular exponentiation block. No dependencies.

package mexp_pkg;

  // Width of the ports and of the arithmetic actually carried out.
  localparam int unsigned DATA_W = 64;
  localparam int unsigned OPND_W = 64;
  localparam int unsigned CNT_W  = $clog2(OPND_W);

  // Configuration port: one 64-bit register at byte address 0.
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned REG_LSB = 3;
  localparam logic [ADDR_W-1-REG_LSB:0] REG_MODULUS = '0;
  localparam logic [DATA_W-1:0] MODULUS_RST = DATA_W'(1);

  // Which modular product the shared multiplier forms.
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,  // base mod m
    OP_ACC    = 2'd1,  // acc * sq mod m
    OP_SQ     = 2'd2   // sq * sq mod m
  } mul_op_e;

  // Source of the delivered result.
  typedef enum logic [1:0] {
    RES_ERR = 2'd0,
    RES_ONE = 2'd1,
    RES_ACC = 2'd2
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_op_e  mul_op;
    logic     e_shift;
    logic     out_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic e_zero;
    logic e_lsb;
    logic e_last;
    logic mul_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/mexp_mulmod.sv
// Bit-serial interleaved shift-add modular multiplier, one multiplier bit
// per cycle, most significant bit first. Depends on mexp_pkg.

module mexp_mulmod import mexp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OPND_W-1:0] x_i,
  input  logic [OPND_W-1:0] y_i,
  input  logic [OPND_W-1:0] m_i,
  output logic              done_o,
  output logic [OPND_W-1:0] prod_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [OPND_W-1:0] x_q, x_d;
  logic [OPND_W-1:0] y_q, y_d;
  logic [OPND_W-1:0] acc_q, acc_d;

  logic [OPND_W+1:0] m_ext, m_two, s0, s1, s2;
  logic [OPND_W-1:0] step;

  // acc < m and x < m, so 2*acc + x < 3m: pick one of three candidates.
  always_comb begin
    m_ext = (OPND_W+2)'(m_i);
    m_two = {m_ext[OPND_W:0], 1'b0};
    s0    = {1'b0, acc_q, 1'b0} + (y_q[OPND_W-1] ? (OPND_W+2)'(x_q) : '0);
    s1    = s0 - m_ext;
    s2    = s0 - m_two;
    if (s0 < m_ext) begin
      step = s0[OPND_W-1:0];
    end else if (s0 < m_two) begin
      step = s1[OPND_W-1:0];
    end else begin
      step = s2[OPND_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = x_i;
      y_d    = y_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = step;
      y_d   = {y_q[OPND_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(OPND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier started while busy");

  a_prod_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (acc_q < m_i))
    else $error("modular product not below modulus");

endmodule

>>> rtl/mexp_ctrl.sv
// Sequencer for right-to-left square-and-multiply: issues reduce, multiply
// and square commands to the datapath. Depends on mexp_pkg.

module mexp_ctrl import mexp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CHECK   = 7'b0000010,
    S_REDUCE  = 7'b0000100,
    S_BIT     = 7'b0001000,
    S_MUL_ACC = 7'b0010000,
    S_MUL_SQ  = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_e;

  state_e   state_q, state_d;
  res_sel_e res_q, res_d;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.mul_op  = OP_REDUCE;
    cmd_o.res_sel = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.m_zero) begin
          res_d   = RES_ERR;
          state_d = S_FINISH;
        end else if (sts_i.e_zero) begin
          res_d   = RES_ONE;
          state_d = S_FINISH;
        end else begin
          res_d           = RES_ACC;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = OP_REDUCE;
          state_d         = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (sts_i.mul_done) begin
          state_d = S_BIT;
        end
      end
      S_BIT: begin
        if (sts_i.e_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = OP_ACC;
          state_d         = S_MUL_ACC;
        end else if (sts_i.e_last) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = OP_SQ;
          cmd_o.e_shift   = 1'b1;
          state_d         = S_MUL_SQ;
        end
      end
      S_MUL_ACC: begin
        if (sts_i.mul_done) begin
          if (sts_i.e_last) begin
            state_d = S_FINISH;
          end else begin
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_op    = OP_SQ;
            cmd_o.e_shift   = 1'b1;
            state_d         = S_MUL_SQ;
          end
        end
      end
      S_MUL_SQ: begin
        if (sts_i.mul_done) begin
          state_d = S_BIT;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= RES_ERR;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |->
      (state_q == S_REDUCE || state_q == S_MUL_ACC || state_q == S_MUL_SQ))
    else $error("multiplier finished outside a multiply state");

endmodule

>>> rtl/mexp_dp.sv
// Datapath: modulus, exponent, accumulator and square registers, the shared
// modular multiplier and the output register. Depends on mexp_pkg, mexp_mulmod.

module mexp_dp import mexp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [OPND_W-1:0] modulus_i,
  input  logic [OPND_W-1:0] base_i,
  input  logic [OPND_W-1:0] exponent_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [OPND_W-1:0] power_result_o,
  output logic              modulus_error_o
);

  logic [OPND_W-1:0] m_q, e_q, acc_q, sq_q;
  mul_op_e           mul_op_q;
  logic              out_valid_q;
  logic [OPND_W-1:0] res_q, res_d;
  logic              err_q;

  logic              mul_done;
  logic [OPND_W-1:0] mul_x, prod;

  // The square register holds the raw base until the first reduction, and
  // the accumulator holds 1 mod m, which doubles as the reduction's multiplicand.
  assign mul_x = (cmd_i.mul_op == OP_SQ) ? sq_q : acc_q;

  mexp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .x_i     (mul_x),
    .y_i     (sq_q),
    .m_i     (m_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q   <= modulus_i;
      e_q   <= exponent_i;
      sq_q  <= base_i;
      acc_q <= (modulus_i == OPND_W'(1)) ? '0 : OPND_W'(1);
    end else begin
      if (cmd_i.e_shift) begin
        e_q <= e_q >> 1;
      end
      if (mul_done) begin
        case (mul_op_q)
          OP_ACC:  acc_q <= prod;
          default: sq_q  <= prod;
        endcase
      end
    end
    if (cmd_i.mul_start) begin
      mul_op_q <= cmd_i.mul_op;
    end
  end

  always_comb begin
    case (cmd_i.res_sel)
      RES_ERR: res_d = '0;
      RES_ONE: res_d = OPND_W'(1);
      default: res_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q <= res_d;
      err_q <= (cmd_i.res_sel == RES_ERR);
    end
  end

  assign sts_o.m_zero   = (m_q == '0);
  assign sts_o.e_zero   = (e_q == '0);
  assign sts_o.e_lsb    = e_q[0];
  assign sts_o.e_last   = (e_q[OPND_W-1:1] == '0);
  assign sts_o.mul_done = mul_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign power_result_o  = res_q;
  assign modulus_error_o = err_q;

endmodule

>>> rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: configuration register,
// controller and datapath. Depends on mexp_pkg, mexp_ctrl, mexp_dp.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o base_i, exponent_i
//   out      output     out_valid_o/out_stall_i power_result_o, modulus_error_o
//   config   input      APB (psel ... pready)   modulus at byte address 0
//
// A zero modulus or zero exponent skips the multiplier. Otherwise, with L the
// bit length of the exponent and P its count of set bits, the products are the
// base reduction, P multiplies and L-1 squares. They all go through one 64-bit
// bit-serial multiplier at one bit a cycle, and each exponent bit also passes
// through a decision state.
// Reset clears the control state and sets the modulus to 1.
// A finished result waits in an output register; the next transaction is
// accepted meanwhile, and only the delivery of its result waits on out_stall_i.

module modular_exponentiation import mexp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input transactions.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DATA_W-1:0] base_i,
  input  logic [DATA_W-1:0] exponent_i,
  // Output transactions.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] power_result_o,
  output logic              modulus_error_o,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DATA_W-1:0] modulus_q;
  logic              reg_hit;
  cmd_t              cmd;
  sts_t              sts;
  logic [OPND_W-1:0] power_result;

  // Only the modulus register exists; writes to any other address are dropped.
  assign reg_hit = (paddr[ADDR_W-1:REG_LSB] == REG_MODULUS);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? modulus_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      modulus_q <= pwdata;
    end
  end

  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Only the low operand-width bits of the modulus and the inputs are used.
  mexp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .modulus_i       (modulus_q[OPND_W-1:0]),
    .base_i          (base_i[OPND_W-1:0]),
    .exponent_i      (exponent_i[OPND_W-1:0]),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .power_result_o  (power_result),
    .modulus_error_o (modulus_error_o)
  );

  assign power_result_o = DATA_W'(power_result);

  // An error result always carries zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && modulus_error_o) |-> (power_result_o == '0))
    else $error("error result with nonzero value");

  // A good result never exceeds the modulus (it equals it only for 1 mod 1).
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !modulus_error_o) |->
      (power_result <= modulus_q[OPND_W-1:0]))
    else $error("result above modulus");

endmodule

>>> dv/tb_modular_exponentiation.sv
// Self-checking testbench for modular_exponentiation: directed and random
// transactions checked against a built-in power predictor.
// Depends on mexp_pkg and the modular_exponentiation RTL.

module tb_modular_exponentiation import mexp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Only the low OPND_W bits of the operands and of the modulus are used.
  localparam logic [DATA_W-1:0] OPERAND_MASK = {DATA_W{1'b1}} >> (DATA_W - OPND_W);
  localparam logic [DATA_W-1:0] ALL_ONES = '1;
  localparam logic [DATA_W-1:0] TOP_BIT = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] PRIME_P = 64'd1000000007;
  localparam logic [ADDR_W-1:0] MODULUS_ADDR = ADDR_W'({REG_MODULUS, {REG_LSB{1'b0}}});

  // The receiver holds off for HOLD_OFF_CYCLES once; the watchdog allows
  // several times that, and more than a full-width exponent takes.
  localparam int unsigned HOLD_OFF_CYCLES = 6000;
  localparam int unsigned WATCHDOG_LIMIT = 50000;
  localparam int unsigned TRAILING_CYCLES = 20;
  localparam int unsigned ITEMS_PER_PHASE = 11;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              err;
  } power_t;

  // The directed plan mixes modulus writes with operand transactions.
  typedef enum logic {
    ROW_MODULUS,
    ROW_OPERANDS
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [DATA_W-1:0] base;     // the new modulus on a ROW_MODULUS row
    logic [DATA_W-1:0] exponent;
    logic              typed;    // expected power typed in below
    power_t            power;
  } plan_row_t;

  // Moduli that the random phases go through, the extremes among them.
  typedef enum logic [2:0] {
    MOD_WIDE,
    MOD_ALL_ONES,
    MOD_TINY,
    MOD_WORD,
    MOD_ZERO,
    MOD_ONE,
    MOD_RANDOM
  } modulus_kind_e;

  localparam int unsigned PLAN_ROWS = 26;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // Modulus of one after reset: a zero exponent still gives one.
    '{ROW_OPERANDS, 64'd5, 64'd0, 1'b1, '{64'd1, 1'b0}},
    '{ROW_OPERANDS, 64'd5, 64'd3, 1'b1, '{64'd0, 1'b0}},
    // Zero modulus: error flag and zero, whatever the exponent.
    '{ROW_MODULUS, 64'd0, 64'd0, 1'b0, '0},
    '{ROW_OPERANDS, 64'd7, 64'd9, 1'b1, '{64'd0, 1'b1}},
    '{ROW_OPERANDS, 64'd7, 64'd0, 1'b1, '{64'd0, 1'b1}},
    '{ROW_OPERANDS, ALL_ONES, ALL_ONES, 1'b1, '{64'd0, 1'b1}},
    // Largest modulus; the all-ones base reduces to zero.
    '{ROW_MODULUS, ALL_ONES, 64'd0, 1'b0, '0},
    '{ROW_OPERANDS, ALL_ONES, ALL_ONES, 1'b1, '{64'd0, 1'b0}},
    '{ROW_OPERANDS, 64'd0, 64'd0, 1'b1, '{64'd1, 1'b0}},
    '{ROW_OPERANDS, 64'd0, 64'd5, 1'b1, '{64'd0, 1'b0}},
    '{ROW_OPERANDS, 64'd1, ALL_ONES, 1'b1, '{64'd1, 1'b0}},
    '{ROW_OPERANDS, ALL_ONES - 1, 64'd1, 1'b1, '{ALL_ONES - 1, 1'b0}},
    '{ROW_OPERANDS, ALL_ONES - 1, 64'd2, 1'b0, '0},
    '{ROW_OPERANDS, 64'd3, ALL_ONES, 1'b0, '0},
    // A prime modulus; base equal to the modulus reduces to zero.
    '{ROW_MODULUS, PRIME_P, 64'd0, 1'b0, '0},
    '{ROW_OPERANDS, 64'd2, 64'd10, 1'b1, '{64'd1024, 1'b0}},
    '{ROW_OPERANDS, PRIME_P, 64'd5, 1'b1, '{64'd0, 1'b0}},
    '{ROW_OPERANDS, ALL_ONES, 64'd1, 1'b0, '0},
    '{ROW_OPERANDS, PRIME_P - 1, 64'd2, 1'b0, '0},
    '{ROW_OPERANDS, 64'd12345, 64'hDEAD_BEEF_0123_4567, 1'b0, '0},
    // Modulus with only the top bit set.
    '{ROW_MODULUS, TOP_BIT, 64'd0, 1'b0, '0},
    '{ROW_OPERANDS, TOP_BIT + 5, 64'd1, 1'b1, '{64'd5, 1'b0}},
    '{ROW_OPERANDS, 64'd3, ALL_ONES, 1'b0, '0},
    '{ROW_OPERANDS, ALL_ONES, 64'h5555_5555_5555_5555, 1'b0, '0},
    '{ROW_MODULUS, 64'hFFFF_FFFF_0000_0001, 64'd0, 1'b0, '0},
    '{ROW_OPERANDS, 64'hAAAA_AAAA_AAAA_AAAA, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, '0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [DATA_W-1:0] base_i;
  logic [DATA_W-1:0] exponent_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [DATA_W-1:0] power_result_o;
  logic              modulus_error_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  modular_exponentiation i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .base_i         (base_i),
    .exponent_i     (exponent_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .power_result_o (power_result_o),
    .modulus_error_o(modulus_error_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Our copy of the modulus register; it only changes while the block is idle.
  logic [DATA_W-1:0] modulus_copy = MODULUS_RST;
  // Powers still owed by the block, oldest first.
  power_t            pending_powers[$];
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;
  // A typed-in expectation travels with the input transaction that carries it.
  logic              offer_typed;
  power_t            offer_power;
  // Phase controls shared with the receiver.
  logic              steady = 1'b0;
  logic              hold_off_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Exact modular product, formed at double width so nothing overflows.
  function automatic logic [DATA_W-1:0] mul_mod(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b,
                                                input logic [DATA_W-1:0] m);
    logic [2*DATA_W-1:0] prod;
    prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    return DATA_W'(prod % {{DATA_W{1'b0}}, m});
  endfunction

  // Right-to-left square-and-multiply over the low OPND_W bits.
  function automatic power_t predict_power(input logic [DATA_W-1:0] base,
                                           input logic [DATA_W-1:0] exponent,
                                           input logic [DATA_W-1:0] modulus);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] e;
    logic [DATA_W-1:0] sq;
    logic [DATA_W-1:0] acc;
    power_t            p;
    m = modulus & OPERAND_MASK;
    e = exponent & OPERAND_MASK;
    p.err = 1'b0;
    if (m == '0) begin
      p.value = '0;
      p.err = 1'b1;
      return p;
    end
    // A zero exponent gives one without reduction, even for a modulus of one.
    if (e == '0) begin
      p.value = DATA_W'(1);
      return p;
    end
    sq = (base & OPERAND_MASK) % m;
    acc = DATA_W'(1) % m;
    while (e != '0) begin
      if (e[0]) begin
        acc = mul_mod(acc, sq, m);
      end
      sq = mul_mod(sq, sq, m);
      e = e >> 1;
    end
    p.value = acc & OPERAND_MASK;
    return p;
  endfunction

  // Idle gaps: mostly none or short, now and then long, never in a steady phase.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(5, 60);
  endfunction

  // Offers one input transaction and returns at the edge that accepts it.
  // The caller must raise or lower in_valid_i again in the same time step.
  task automatic send_operands(input logic [DATA_W-1:0] base,
                               input logic [DATA_W-1:0] exponent,
                               input logic              typed,
                               input power_t            power);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    base_i <= base;
    exponent_i <= exponent;
    offer_typed <= typed;
    offer_power <= power;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stops offering and waits until every owed power has been delivered.
  // The first edge lets the monitor record a transaction accepted just now.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_powers.size() != 0) @(posedge clk_i);
  endtask

  // APB write of the modulus: setup cycle, then the access cycle.
  task automatic write_modulus(input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODULUS_ADDR;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    modulus_copy = value;
  endtask

  // Receiver: random stall stretches, plus one long hold-off on request so
  // that the output register and the operand stage both fill up.
  initial begin
    int unsigned span;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        span = pick_gap();
        out_stall_i <= !steady && ($urandom_range(0, 2) == 0);
        repeat (span + 1) @(posedge clk_i);
      end
    end
  end

  // Monitor: predicts each accepted input transaction, checks each delivered
  // output transaction against the oldest owed power, and runs the watchdog.
  always @(posedge clk_i) begin : monitor
    power_t owed;
    logic   active;
    active = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        active = 1'b1;
        if (offer_typed) begin
          pending_powers.push_back(offer_power);
        end else begin
          pending_powers.push_back(predict_power(base_i, exponent_i, modulus_copy));
        end
      end
      if (out_valid_o && !out_stall_i) begin
        active = 1'b1;
        if (pending_powers.size() == 0) begin
          $error("unexpected result: power_result %h modulus_error %b",
                 power_result_o, modulus_error_o);
          mismatch_count++;
        end else begin
          owed = pending_powers.pop_front();
          if (power_result_o !== owed.value) begin
            $error("power_result: expected %h, actual %h", owed.value, power_result_o);
            mismatch_count++;
          end
          if (modulus_error_o !== owed.err) begin
            $error("modulus_error: expected %b, actual %b", owed.err, modulus_error_o);
            mismatch_count++;
          end
        end
      end
      if (psel && penable && pwrite) begin
        active = 1'b1;
      end
      if (active) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_modular_exponentiation: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] exponent;
    logic [DATA_W-1:0] modulus;
    int unsigned       nbits;
    modulus_kind_e     kind;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    base_i = '0;
    exponent_i = '0;
    offer_typed = 1'b0;
    offer_power = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed plan; the first rows run on the reset value of the modulus.
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (DIRECTED_PLAN[i].kind == ROW_MODULUS) begin
        drain();
        write_modulus(DIRECTED_PLAN[i].base);
      end else begin
        send_operands(DIRECTED_PLAN[i].base, DIRECTED_PLAN[i].exponent,
                      DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].power);
      end
    end

    // Random phases, one per modulus kind. Most exponents are a few bits long
    // to keep the run short; about one in ten uses the full width.
    kind = kind.first();
    do begin
      drain();
      case (kind)
        MOD_WIDE:     modulus = {1'b1, 31'($urandom), 32'($urandom)};
        MOD_ALL_ONES: modulus = ALL_ONES;
        MOD_TINY:     modulus = DATA_W'($urandom_range(2, 1000));
        MOD_WORD:     modulus = DATA_W'($urandom);
        MOD_ZERO:     modulus = '0;
        MOD_ONE:      modulus = DATA_W'(1);
        default:      modulus = {$urandom, $urandom};
      endcase
      write_modulus(modulus);
      // Small items finish quickly whatever the modulus; this phase is
      // where the receiver holds off and the sender backs up behind it.
      if (kind == MOD_TINY) begin
        hold_off_req = 1'b1;
      end
      steady = (kind == MOD_WORD);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          exponent = {$urandom, $urandom};
        end else begin
          nbits = $urandom_range(0, 8);
          exponent = {$urandom, $urandom} & ((DATA_W'(1) << nbits) - 1);
        end
        case ($urandom_range(0, 3))
          0:       base = DATA_W'($urandom_range(0, 3));
          1:       base = modulus_copy + DATA_W'($urandom_range(0, 2));
          default: base = {$urandom, $urandom};
        endcase
        send_operands(base, exponent, 1'b0, '0);
      end
      steady = 1'b0;
      kind = kind.next();
    end while (kind != kind.first());

    drain();
    // Any result delivered from here on has nothing waiting for it.
    repeat (TRAILING_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_modular_exponentiation: clean");
    end else begin
      $display("tb_modular_exponentiation: errors");
    end
    $finish;
  end

endmodule
